// ===== rtl/core/range_max_segment_tree_defines.svh =====
`ifndef RANGE_MAX_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RMST_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RMST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rmst_pkg.sv =====
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 64;
  localparam int MAX_W = 63;

  typedef enum logic {
    OP_RAISE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One request transaction as handed to the sequencer
  typedef struct packed {
    op_e                opcode;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   range_low;
    logic [POS_W-1:0]   range_high;
  } cmd_t;

endpackage

// ===== rtl/core/rmst_mem.sv =====
`timescale 1ns / 1ps

module rmst_mem #(
  parameter int AW = 11,
  parameter int DW = 63
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rmst_seq.sv =====
`timescale 1ns / 1ps
`include "range_max_segment_tree_defines.svh"

module rmst_seq #(
  parameter int LEAVES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  rmst_pkg::cmd_t             cmd_i,
  output logic                       cmd_ready_o,
  output logic                       res_valid_o,
  output logic [rmst_pkg::MAX_W-1:0] res_data_o,
  input  logic                       res_ready_i
);

  localparam int LVL = $clog2(LEAVES);
  localparam int AW  = LVL + 1;
  localparam int DW  = rmst_pkg::MAX_W;
  localparam int EW  = ((LVL > rmst_pkg::POS_W) ? LVL : rmst_pkg::POS_W) + 1;
  localparam logic [EW-1:0]  LEAVES_E = EW'(LEAVES);
  localparam logic [LVL-1:0] LAST_I   = LVL'(LEAVES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_QEND
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW:0]   l_q, l_d, r_q, r_d;
  logic [DW-1:0] val_q, val_d;
  logic [DW-1:0] best_q, best_d;
  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [AW:0]   l_n, r_n;
  logic [LVL-1:0] lo_idx, hi_idx;

  // Clamp a position to the last leaf
  function automatic logic [LVL-1:0] clamp_pos(input logic [rmst_pkg::POS_W-1:0] p);
    logic [LVL-1:0] res;
    if (EW'(p) >= LEAVES_E) begin
      res = LAST_I;
    end else begin
      res = LVL'(p);
    end
    return res;
  endfunction

  rmst_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign lo_idx = clamp_pos(cmd_i.range_low);
  assign hi_idx = clamp_pos(cmd_i.range_high);

  // Sequence clear, path update and range walk
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    l_d         = l_q;
    r_d         = r_q;
    val_d       = val_q;
    best_d      = best_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_addr_q;
    mem_wdata   = (mem_rdata > val_q) ? mem_rdata : val_q;
    mem_re      = 1'b0;
    mem_raddr   = k_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    l_n         = l_q;
    r_n         = r_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.opcode == rmst_pkg::OP_RAISE) begin
            k_d     = {1'b1, clamp_pos(cmd_i.position)};
            // Nodes never drop below zero, so a negative value merges as zero
            val_d   = cmd_i.value[rmst_pkg::VAL_W-1] ? '0 : cmd_i.value[DW-1:0];
            state_d = ST_UPD;
          end else begin
            l_d     = {2'b01, lo_idx};
            r_d     = {2'b01, hi_idx} + 1'b1;
            best_d  = '0;
            state_d = ST_QRY;
          end
        end
      end
      ST_UPD: begin
        // Write back the node read last cycle, read its parent
        mem_we = rd_pend_q;
        if (k_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = k_q;
          k_d       = k_q >> 1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY: begin
        if (l_q >= r_q) begin
          state_d = ST_QEND;
        end else begin
          if (l_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = l_q[AW-1:0];
            l_n       = l_q + 1'b1;
          end else if (r_q[0]) begin
            r_n       = r_q - 1'b1;
            mem_re    = 1'b1;
            mem_raddr = r_n[AW-1:0];
          end
          // Climb a level once both bounds are even
          if (!l_n[0] && !r_n[0]) begin
            l_d = l_n >> 1;
            r_d = r_n >> 1;
          end else begin
            l_d = l_n;
            r_d = r_n;
          end
        end
      end
      ST_QEND: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Fold returning node values into the running maximum
    if (rd_pend_q && (state_q == ST_QRY) && (mem_rdata > best_q)) begin
      best_d = mem_rdata;
    end

    rd_pend_d = mem_re;
    rd_addr_d = mem_raddr;
  end

  assign res_data_o = best_q;

  // Hold state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      k_q       <= '0;
      l_q       <= '0;
      r_q       <= '0;
      val_q     <= '0;
      best_q    <= '0;
      rd_pend_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      k_q       <= k_d;
      l_q       <= l_d;
      r_q       <= r_d;
      val_q     <= val_d;
      best_q    <= best_d;
      rd_pend_q <= rd_pend_d;
      rd_addr_q <= rd_addr_d;
    end
  end

  `RMST_ASSERT(a_no_rw_collision, clk_i, rst_ni, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same node")
  `RMST_ASSERT(a_no_write_in_query, clk_i, rst_ni, state_q == ST_QRY || state_q == ST_QEND, !mem_we, "node written during a query")
  `RMST_ASSERT_NEXT(a_result_to_idle, clk_i, rst_ni, res_valid_o && res_ready_i, state_q == ST_IDLE && !rd_pend_q, "sequencer not idle after result hand-off")

endmodule

// ===== rtl/core/range_max_segment_tree.sv =====
`timescale 1ns / 1ps

// Range-maximum segment tree over LEAVES leaf positions, kept in one memory of
// 2*SPAN nodes (SPAN = LEAVES rounded up to a power of two) with a registered
// read port. One transaction is worked at a time. An update walks the path
// from leaf to root, one read-modify-write per level. A query walks both
// bounds up the tree, reading one node at a time through the single memory
// read port. The result sits in an output register, so a finished query can
// wait there while the next transaction is taken. After reset a clearing pass
// writes zero to every node, one a cycle, during which in_stall_o stays high.
module range_max_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [rmst_pkg::POS_W-1:0]   position_i,
  input  logic signed [rmst_pkg::VAL_W-1:0] value_i,
  input  logic [rmst_pkg::POS_W-1:0]   range_low_i,
  input  logic [rmst_pkg::POS_W-1:0]   range_high_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rmst_pkg::MAX_W-1:0]   range_maximum_o
);

  rmst_pkg::cmd_t             cmd;
  logic                       cmd_ready;
  logic                       res_valid;
  logic                       res_ready;
  logic [rmst_pkg::MAX_W-1:0] res_data;
  logic                       out_valid_q, out_valid_d;
  logic [rmst_pkg::MAX_W-1:0] range_maximum_q, range_maximum_d;

  // Pack the request transaction
  always_comb begin
    cmd.opcode     = rmst_pkg::op_e'(opcode_i);
    cmd.position   = position_i;
    cmd.value      = value_i;
    cmd.range_low  = range_low_i;
    cmd.range_high = range_high_i;
  end

  assign in_stall_o = !cmd_ready;

  rmst_seq #(
    .LEAVES (LEAVES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_ready_i (res_ready)
  );

  // Load the output register when empty or draining
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d     = out_valid_q;
    range_maximum_d = range_maximum_q;
    if (res_valid && res_ready) begin
      out_valid_d     = 1'b1;
      range_maximum_d = res_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      range_maximum_q <= '0;
    end else begin
      out_valid_q     <= out_valid_d;
      range_maximum_q <= range_maximum_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign range_maximum_o = range_maximum_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int POS_W = rmst_pkg::POS_W;
  localparam int VAL_W = rmst_pkg::VAL_W;
  localparam int MAX_W = rmst_pkg::MAX_W;
  localparam int LEAVES = 1024;
  localparam int SPAN = 1 << $clog2(LEAVES);
  localparam int CLK_PERIOD = 10;
  localparam int RANDOM_ITEMS = 850;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [VAL_W-1:0] TOP_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] TOP_NEG = 64'h8000_0000_0000_0000;
  localparam int TABLE_ROWS = 24;

  // One directed transaction; fixed rows carry a hand-written expected maximum
  typedef struct packed {
    rmst_pkg::op_e    op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    bit               fixed;
    logic [MAX_W-1:0] fixed_max;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic opcode_i;
  logic [POS_W-1:0] position_i;
  logic signed [VAL_W-1:0] value_i;
  logic [POS_W-1:0] range_low_i;
  logic [POS_W-1:0] range_high_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [MAX_W-1:0] range_maximum_o;

  // Predictor state: node k has children 2k and 2k+1, leaf i at SPAN+i
  logic signed [VAL_W-1:0] tree_node [1:2*SPAN-1];
  logic [MAX_W-1:0] pending_maxima [$];
  stim_row_t directed_rows [0:TABLE_ROWS-1];

  int mismatches = 0;
  int results_checked = 0;
  int raises_sent = 0;
  int queries_sent = 0;
  int cycle_count = 0;
  bit burst_mode = 1'b0;
  bit hold_off_request = 1'b0;

  range_max_segment_tree #(
    .LEAVES(LEAVES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .range_maximum_o(range_maximum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_leaf(logic [POS_W-1:0] p);
    if (p >= LEAVES) return 32'(LEAVES - 1);
    return 32'(p);
  endfunction

  // Raise every node from the leaf up to the root to at least v
  task automatic raise_path(int unsigned leaf, logic signed [VAL_W-1:0] v);
    int unsigned k;
    k = SPAN + leaf;
    while (k >= 1) begin
      if (tree_node[k] < v) tree_node[k] = v;
      k = k >> 1;
    end
  endtask

  // Bottom-up range walk over the inclusive leaf range, floored at zero
  function automatic logic [MAX_W-1:0] span_maximum(int unsigned lo, int unsigned hi);
    logic signed [VAL_W-1:0] best;
    int unsigned l;
    int unsigned r;
    best = '0;
    if (lo > hi) return '0;
    l = SPAN + lo;
    r = SPAN + hi + 1;
    while (l < r) begin
      if ((l & 1) != 0) begin
        if (tree_node[l] > best) best = tree_node[l];
        l++;
      end
      if ((r & 1) != 0) begin
        r--;
        if (tree_node[r] > best) best = tree_node[r];
      end
      l = l >> 1;
      r = r >> 1;
    end
    return best[MAX_W-1:0];
  endfunction

  // Offer one transaction, hold it until taken, then update the predictor
  task automatic send_item(input rmst_pkg::op_e op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi, input bit fixed,
                           input logic [MAX_W-1:0] fixed_max);
    int gap;
    logic [MAX_W-1:0] model_max;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    position_i   <= pos;
    value_i      <= val;
    range_low_i  <= lo;
    range_high_i <= hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == rmst_pkg::OP_RAISE) begin
      raise_path(clamp_leaf(pos), val);
      raises_sent++;
    end else begin
      model_max = span_maximum(clamp_leaf(lo), clamp_leaf(hi));
      pending_maxima.push_back(fixed ? fixed_max : model_max);
      queries_sent++;
    end
  endtask

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 64'($urandom_range(0, 100000));
      5, 6:          return {$urandom | 32'h8000_0000, $urandom};
      7:             return {$urandom, $urandom};
      8:             return {24'h0, 8'($urandom_range(0, 255)), $urandom};
      default:       return $urandom_range(0, 1) ? TOP_POS : TOP_NEG;
    endcase
  endfunction

  // Stimulus: reset, directed table, then random traffic
  initial begin : stimulus
    int lo;
    int hi;
    int swap;
    rmst_pkg::op_e op;
    stim_row_t row;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = rmst_pkg::OP_RAISE;
    position_i   = '0;
    value_i      = '0;
    range_low_i  = '0;
    range_high_i = '0;
    foreach (tree_node[k]) tree_node[k] = '0;

    directed_rows = '{
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd0,    10'd1023, 1'b1, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd5,    10'd3,    1'b1, 63'd0},
      '{rmst_pkg::OP_RAISE, 10'd0,    TOP_POS,    10'd1023, 10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd1023, TOP_NEG,    10'd0,    10'd0,    1'b1,
        TOP_POS[MAX_W-1:0]},
      '{rmst_pkg::OP_RAISE, 10'd1023, TOP_NEG,    10'd0,    10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1023, 10'd1023, 1'b1, 63'd0},
      '{rmst_pkg::OP_RAISE, 10'd1023, 64'd5,      10'd0,    10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1023, 10'd1023, 1'b1, 63'd5},
      '{rmst_pkg::OP_RAISE, 10'd512,  {64{1'b1}}, 10'd0,    10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd512,  10'd512,  1'b1, 63'd0},
      '{rmst_pkg::OP_RAISE, 10'd511,  64'd100,    10'd0,    10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd511,  10'd512,  1'b1, 63'd100},
      '{rmst_pkg::OP_RAISE, 10'd1023, 64'd3,      10'd0,    10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1000, 10'd1023, 1'b1, 63'd5},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1,    10'd1023, 1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1023, 10'd0,    1'b1, 63'd0},
      '{rmst_pkg::OP_RAISE, 10'd300,  TOP_POS - 64'd1, 10'd0, 10'd0,  1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd0,    10'd1023, 1'b1,
        TOP_POS[MAX_W-1:0]},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1,    10'd1023, 1'b0, 63'd0},
      '{rmst_pkg::OP_RAISE, 10'd700,  64'h1_0000_0000, 10'd0, 10'd0,  1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd301,  10'd1022, 1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd513,  10'd767,  1'b0, 63'd0},
      '{rmst_pkg::OP_RAISE, 10'd1,    64'd1,      10'd0,    10'd0,    1'b0, 63'd0},
      '{rmst_pkg::OP_QUERY, 10'd0,    64'd0,      10'd1,    10'd1,    1'b0, 63'd0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < TABLE_ROWS; i++) begin
      row = directed_rows[i];
      send_item(row.op, row.pos, row.val, row.lo, row.hi, row.fixed, row.fixed_max);
    end

    // Random traffic; one burst of queries runs against a long output hold-off
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) begin
        hold_off_request = 1'b1;
        burst_mode = 1'b1;
      end else if (i >= 140 && (i % 50) == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      op = (i >= 100 && i < 140) ? rmst_pkg::OP_QUERY
                                 : rmst_pkg::op_e'($urandom_range(0, 1));
      lo = $urandom_range(0, 1023);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          hi = lo + $urandom_range(0, 15);
          if (hi > 1023) hi = 1023;
        end
        6: begin
          hi = $urandom_range(0, 1023);
          if (hi > lo) begin
            swap = lo;
            lo = hi;
            hi = swap;
          end
        end
        7: hi = $urandom_range(0, 1023);
        8: begin
          lo = $urandom_range(0, 31);
          hi = $urandom_range(992, 1023);
        end
        default: hi = lo;
      endcase
      send_item(op, POS_W'($urandom_range(0, 1023)), draw_value(),
                POS_W'(lo), POS_W'(hi), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow for trailing activity
    while (pending_maxima.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d updates and %0d range queries; %0d results compared.",
             raises_sent, queries_sent, results_checked);
    $display("Traffic included a %0d-cycle output hold-off with the input backed up.",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: stall for a drawn number of cycles or the requested long hold-off, then take one transaction
  initial begin : result_sink
    int wait_cycles;
    out_stall_i = 1'b0;
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        wait_cycles = LONG_HOLD;
      end else begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expected maximum
  always @(posedge clk_i) begin : result_check
    logic [MAX_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (pending_maxima.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual %0h",
                 $time, range_maximum_o);
        mismatches++;
      end else begin
        want = pending_maxima.pop_front();
        if (range_maximum_o !== want) begin
          $display("%0t: range_maximum expected %0h, actual %0h",
                   $time, want, range_maximum_o);
          mismatches++;
        end
      end
    end
  end

  // Bound the run in cycles
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_maxima.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
